// File: rtl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants of the LZW encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int FIRST_FREE = 256;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SLOT  = 5'b00010,
    ST_DICT  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

endpackage

// File: rtl/lzw_ram.sv
// ----------------------------------------------------------------------------
// lzw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzw_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lzw_out.sv
// ----------------------------------------------------------------------------
// lzw_out
// Output register holding one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module lzw_out #(
  parameter int CODE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [CODE_BITS-1:0] push_code,
  input  logic                 push_end,
  input  logic                 push_last,
  output logic                 can_push,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] code,
  output logic                 message_end,
  output logic                 run_last
);

  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      code        <= push_code;
      message_end <= push_end;
      run_last    <= push_last;
    end
  end

endmodule

// File: rtl/lzw_encoder.sv
// ----------------------------------------------------------------------------
// lzw_encoder
// LZW compressor: one message byte per input beat, codes out per result beat.
// ----------------------------------------------------------------------------
// The first byte of a message is taken as the prefix without a lookup. Every
// later byte looks up the string (prefix, byte) in a hashed slot table with
// linear probing; each probe is two chained registered memory reads (slot
// table, then code table) and a compare, in the states SLOT, DICT and CHECK,
// and a final byte adds the FLUSH state for the flushed code. A beat is
// accepted only in idle; a finished code waits in the output register while
// the next byte is taken. Slot entries are checked against the code table, so
// no clearing is needed after reset or between messages.
// ----------------------------------------------------------------------------
module lzw_encoder #(
  parameter int CODE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] code,
  output logic                 message_end,
  output logic                 run_last
);

  import lzw_pkg::*;

  localparam int HASH_BITS = CODE_BITS + 1;
  localparam int DICT_BITS = CODE_BITS + BYTE_BITS + HASH_BITS;
  localparam logic [CODE_BITS:0] DICT_SIZE = {1'b1, {CODE_BITS{1'b0}}};
  localparam logic [CODE_BITS:0] FREE_BASE = (CODE_BITS + 1)'(FIRST_FREE);

  state_t                 state;
  logic [CODE_BITS-1:0]   prefix;
  logic                   prefix_valid;
  logic [CODE_BITS:0]     next_free;
  logic [HASH_BITS-1:0]   probe;
  logic [BYTE_BITS-1:0]   cur_byte;
  logic                   cur_last;

  logic [CODE_BITS-1:0]   slot_code;
  logic [DICT_BITS-1:0]   dict_rdata;
  logic [CODE_BITS-1:0]   dict_prefix;
  logic [BYTE_BITS-1:0]   dict_byte;
  logic [HASH_BITS-1:0]   dict_slot;
  logic [HASH_BITS-1:0]   hash;
  logic                   occupied;
  logic                   hit;
  logic                   can_push;
  logic                   push;
  logic                   push_end;
  logic                   push_last;
  logic                   learn;

  assign in_ready = (state == ST_IDLE);

  // hash of prefix and incoming byte
  assign hash = {data_byte, {(HASH_BITS - BYTE_BITS){1'b0}}} ^ {1'b0, prefix};

  assign dict_prefix = dict_rdata[DICT_BITS-1 -: CODE_BITS];
  assign dict_byte   = dict_rdata[HASH_BITS + BYTE_BITS - 1 -: BYTE_BITS];
  assign dict_slot   = dict_rdata[HASH_BITS-1:0];

  // a slot is live only if its code is learned and points back at the slot
  assign occupied = ({1'b0, slot_code} >= FREE_BASE) && ({1'b0, slot_code} < next_free)
                    && (dict_slot == probe);
  assign hit      = occupied && (dict_prefix == prefix) && (dict_byte == cur_byte);

  always_comb begin
    push      = 1'b0;
    push_end  = 1'b0;
    push_last = 1'b0;
    learn     = 1'b0;
    case (state)
      ST_CHECK: begin
        if (hit) begin
          push = 1'b0;
        end else if (occupied) begin
          push = 1'b0;
        end else if (can_push) begin
          push      = 1'b1;
          push_last = !cur_last;
          learn     = (next_free < DICT_SIZE);
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push      = 1'b1;
          push_end  = 1'b1;
          push_last = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= FREE_BASE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!prefix_valid) begin
              prefix       <= CODE_BITS'(data_byte);
              prefix_valid <= 1'b1;
              state        <= last_byte ? ST_FLUSH : ST_IDLE;
            end else begin
              state <= ST_SLOT;
            end
          end
        end
        ST_SLOT: begin
          state <= ST_DICT;
        end
        ST_DICT: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (hit) begin
            prefix <= slot_code;
            state  <= cur_last ? ST_FLUSH : ST_IDLE;
          end else if (occupied) begin
            state <= ST_SLOT;
          end else if (can_push) begin
            prefix <= CODE_BITS'(cur_byte);
            if (learn) begin
              next_free <= next_free + 1'b1;
            end
            state <= cur_last ? ST_FLUSH : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (can_push) begin
            prefix       <= '0;
            prefix_valid <= 1'b0;
            next_free    <= FREE_BASE;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cur_byte <= data_byte;
      cur_last <= last_byte;
      probe    <= hash;
    end else if (state == ST_CHECK && !hit && occupied) begin
      probe <= probe + 1'b1;
    end
  end

  lzw_ram #(
    .ADDR_BITS (HASH_BITS),
    .DATA_BITS (CODE_BITS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (learn),
    .waddr (probe),
    .wdata (next_free[CODE_BITS-1:0]),
    .re    (state == ST_SLOT),
    .raddr (probe),
    .rdata (slot_code)
  );

  lzw_ram #(
    .ADDR_BITS (CODE_BITS),
    .DATA_BITS (DICT_BITS)
  ) u_code_ram (
    .clk   (clk),
    .we    (learn),
    .waddr (next_free[CODE_BITS-1:0]),
    .wdata ({prefix, cur_byte, probe}),
    .re    (state == ST_DICT),
    .raddr (slot_code),
    .rdata (dict_rdata)
  );

  lzw_out #(
    .CODE_BITS (CODE_BITS)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_code   (prefix),
    .push_end    (push_end),
    .push_last   (push_last),
    .can_push    (can_push),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code        (code),
    .message_end (message_end),
    .run_last    (run_last)
  );

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    (next_free >= FREE_BASE) && (next_free <= DICT_SIZE))
    else $error("next free code out of range");

  a_learn_room: assert property (@(posedge clk) disable iff (rst)
    learn |-> (state == ST_CHECK) && (next_free < DICT_SIZE) && prefix_valid)
    else $error("string learned without room or prefix");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("result beat overwrites a waiting beat");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && push) |=> !prefix_valid && (next_free == FREE_BASE))
    else $error("message state not cleared after flush");

  a_probe_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SLOT || state == ST_DICT || state == ST_CHECK) |-> prefix_valid)
    else $error("dictionary probe without a held prefix");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZW encoder, run with a 9-bit code width.
// A queue of message bytes feeds a valid/ready driver with random gaps. The
// bench keeps its own dictionary and prefix and predicts every code beat. A
// monitor with random stalls compares each code beat, field by field, with
// the oldest prediction. Directed messages come first, then random ones that
// mix small alphabets for long matches, wide alphabets that fill the
// dictionary, and noise with the last flag set at random.
// ----------------------------------------------------------------------------
module tb;
  import lzw_pkg::*;

  localparam int CW          = 9;          // small width so the dictionary fills
  localparam int DICT_CODES  = 1 << CW;
  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [CW-1:0] code;
    logic          message_end;
    logic          run_last;
  } code_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         gap;
    bit         drain;
  } msg_byte_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [7:0]    data_byte = '0;
  logic          last_byte = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CW-1:0] code;
  logic          message_end;
  logic          run_last;

  msg_byte_t     byte_queue[$];
  code_beat_t    expected_codes[$];

  // encoder state as predicted
  logic [CW-1:0] held_code = '0;
  bit            held = 1'b0;
  int            free_code = FIRST_FREE;
  int            learned[bit [CW+7:0]];

  int            errors = 0;
  int            wait_cnt = 0;
  int            stall_cnt = 0;
  int            beats_out = 0;
  int            idle_cycles = 0;

  always #5 clk = ~clk;

  lzw_encoder #(
    .CODE_BITS (CW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code        (code),
    .message_end (message_end),
    .run_last    (run_last)
  );

  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    bit [CW+7:0] key;
    code_beat_t  beat;
    key = {held_code, b};
    if (!held) begin
      held_code = CW'(b);
      held      = 1'b1;
    end else if (learned.exists(key)) begin
      held_code = CW'(learned[key]);
    end else begin
      beat.code        = held_code;
      beat.message_end = 1'b0;
      beat.run_last    = ~fin;
      expected_codes.insert(expected_codes.size(), beat);
      if (free_code < DICT_CODES) begin
        learned[key] = free_code;
        free_code++;
      end
      held_code = CW'(b);
    end
    if (fin) begin
      beat.code        = held_code;
      beat.message_end = 1'b1;
      beat.run_last    = 1'b1;
      expected_codes.insert(expected_codes.size(), beat);
      held_code = '0;
      held      = 1'b0;
      free_code = FIRST_FREE;
      learned.delete();
    end
  endfunction

  // calm stretches with no idling, otherwise mostly short gaps and a few long
  function automatic int pick_gap(input int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((idx / 80) % 4 == 3) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic fin, input bit drain = 1'b0);
    msg_byte_t item;
    item.data  = b;
    item.fin   = fin;
    item.gap   = pick_gap(byte_queue.size());
    item.drain = drain;
    byte_queue.insert(byte_queue.size(), item);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      data_byte <= '0;
      last_byte <= 1'b0;
      wait_cnt  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(data_byte, last_byte);
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (byte_queue[0].drain && expected_codes.size() != 0) begin
          in_valid <= 1'b0;
        end else if (wait_cnt < byte_queue[0].gap) begin
          in_valid <= 1'b0;
          wait_cnt <= wait_cnt + 1;
        end else begin
          in_valid  <= 1'b1;
          data_byte <= byte_queue[0].data;
          last_byte <= byte_queue[0].fin;
          wait_cnt  <= 0;
          void'(byte_queue.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    code_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out <= beats_out + 1;
        if (expected_codes.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat code %0d message_end %0b run_last %0b",
                   $time, code, message_end, run_last);
        end else begin
          want = expected_codes.pop_front();
          if (code !== want.code) begin
            errors++;
            $display("%0t: code expected %0d actual %0d", $time, want.code, code);
          end
          if (message_end !== want.message_end) begin
            errors++;
            $display("%0t: message_end expected %0b actual %0b", $time,
                     want.message_end, message_end);
          end
          if (run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b actual %0b", $time,
                     want.run_last, run_last);
          end
        end
      end
      if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_ready <= 1'b1;
        if ((beats_out / 64) % 4 != 2 && $urandom_range(0, 3) == 0) begin
          stall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         kind;
    int         len;
    int         span;
    int         msgs;
    bit         noisy;
    logic [7:0] base;
    logic       fin;

    // single-byte messages at both extremes
    add_byte(8'h00, 1'b1);
    add_byte(8'hff, 1'b1);
    // alternating pair, repeats build longer strings
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b1);
    // run of one byte
    for (int k = 0; k < 7; k++) add_byte(8'h55, k == 6);
    // miss on the final byte gives two beats
    add_byte(8'haa, 1'b0);
    add_byte(8'h55, 1'b1);
    // hit on the final byte
    add_byte(8'h5a, 1'b0);
    add_byte(8'ha5, 1'b0);
    add_byte(8'h5a, 1'b0);
    add_byte(8'ha5, 1'b1);

    msgs = 0;
    while (byte_queue.size() < ITEM_TARGET) begin
      kind  = (msgs == 0) ? 0 : $urandom_range(0, 24);
      noisy = 1'b0;
      if (kind == 0) begin
        // wide alphabet, long enough to fill the dictionary
        len  = $urandom_range(300, 340);
        span = 256;
      end else if (kind < 4) begin
        len   = $urandom_range(1, 60);
        span  = 256;
        noisy = 1'b1;
      end else begin
        len = $urandom_range(1, 40);
        case ($urandom_range(0, 4))
          0: span = 2;
          1: span = 3;
          2: span = 4;
          3: span = 8;
          default: span = 256;
        endcase
      end
      // keep the total close to the target
      if (byte_queue.size() + len > ITEM_TARGET + 10) begin
        len = ITEM_TARGET + 10 - byte_queue.size();
      end
      base = $urandom_range(0, 255);
      for (int k = 0; k < len; k++) begin
        fin = (k == len - 1) || (noisy && $urandom_range(0, 7) == 0);
        add_byte(base + 8'($urandom_range(0, span - 1)), fin, k == 0 && msgs % 6 == 5);
      end
      msgs++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || in_valid || expected_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
